[sv/pprs_pkg.sv]
// Shared types, constants and helper functions of the palette pixel replication scaler.
`timescale 1ns / 1ps

package pprs_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_SRC_WIDTH     = 256;
  localparam int DEF_SRC_HEIGHT    = 240;
  localparam int DEF_PALETTE_DEPTH = 512;

  // Job queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 14;

  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_FACTOR  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_PITCH     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_WIDTH  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HEIGHT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CROP_ENABLE   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CROP_TOP      = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_CROP_LEFT     = 3'd7;

  // Pixel format codes.
  localparam logic [1:0] FMT_16 = 2'd0;
  localparam logic [1:0] FMT_24 = 2'd1;
  localparam logic [1:0] FMT_32 = 2'd2;

  // Input mode codes.
  localparam logic MODE_PIXEL   = 1'b0;
  localparam logic MODE_PALETTE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [8:0]  color_index;
    logic [31:0] palette_word;
    logic        frame_start;
  } item_t;

  typedef struct packed {
    logic [23:0] byte_offset;
    logic [31:0] pixel_value;
    logic        last_write;
  } result_t;

  typedef struct packed {
    logic [2:0]  scale_factor;
    logic [1:0]  pixel_format;
    logic [13:0] row_pitch;
    logic [8:0]  window_width;
    logic [7:0]  window_height;
    logic        crop_enable;
    logic [7:0]  crop_top;
    logic [7:0]  crop_left;
  } cfg_t;

  // One in-window pixel, ready for replication.
  typedef struct packed {
    logic [23:0] row_start;
    logic [13:0] col_start;
    logic [31:0] colour;
  } job_t;

  typedef struct packed {
    logic                   empty;
    logic [QUEUE_LVL_W-1:0] level;
  } queue_status_t;

  function automatic logic [2:0] fmt_bytes(logic [1:0] fmt);
    logic [2:0] bytes;
    unique case (fmt)
      FMT_16:  bytes = 3'd2;
      FMT_24:  bytes = 3'd3;
      FMT_32:  bytes = 3'd4;
      default: bytes = 3'd0;
    endcase
    return bytes;
  endfunction

  function automatic logic [31:0] fmt_mask(logic [1:0] fmt);
    logic [31:0] mask;
    unique case (fmt)
      FMT_16:  mask = 32'h0000_FFFF;
      FMT_24:  mask = 32'h00FF_FFFF;
      FMT_32:  mask = 32'hFFFF_FFFF;
      default: mask = 32'h0000_0000;
    endcase
    return mask;
  endfunction

endpackage

[sv/pprs_front.sv]
// Front part: palette store, raster counters, window test and offset bases.
`timescale 1ns / 1ps

module pprs_front import pprs_pkg::*; #(
  parameter int SRC_WIDTH     = DEF_SRC_WIDTH,
  parameter int SRC_HEIGHT    = DEF_SRC_HEIGHT,
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          push,
  input  item_t         item,
  output logic          full,
  input  queue_status_t q_status,
  output logic          q_push,
  output job_t          q_data
);

  localparam int CW = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
  localparam int RW = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [CW-1:0] column;
  logic [RW-1:0] row;
  logic [31:0]   palette_store [PALETTE_DEPTH];
  logic [31:0]   rd_data;

  logic        s1_valid;
  logic [11:0] s1_ox_f;
  logic [11:0] s1_oy_f;
  logic        s1_in_range;

  logic          accept;
  logic [CW-1:0] col_now;
  logic [RW-1:0] row_now;
  logic [10:0]   col_ext;
  logic [10:0]   row_ext;
  logic [10:0]   org_x;
  logic [10:0]   org_y;
  logic [10:0]   x_end;
  logic [10:0]   y_end;
  logic          in_window;
  logic          emit;
  logic [9:0]    ox;
  logic [9:0]    oy;
  logic [11:0]   ox_f;
  logic [11:0]   oy_f;
  logic          col_last;
  logic          row_last;
  logic [12:0]   idx_wide;
  logic          in_range;
  logic [AW-1:0] addr;
  logic [2:0]    bytes;

  assign accept = push && !full;

  // Room is kept for the pixel that sits in the read stage.
  assign full = ({1'b0, q_status.level} + {{QUEUE_LVL_W{1'b0}}, s1_valid})
                >= (QUEUE_LVL_W + 1)'(QUEUE_DEPTH);

  always_comb begin
    col_now   = item.frame_start ? '0 : column;
    row_now   = item.frame_start ? '0 : row;
    col_ext   = 11'(col_now);
    row_ext   = 11'(row_now);
    org_x     = cfg.crop_enable ? {3'b000, cfg.crop_left} : 11'd0;
    org_y     = cfg.crop_enable ? {3'b000, cfg.crop_top} : 11'd0;
    x_end     = org_x + {2'b00, cfg.window_width};
    y_end     = org_y + {3'b000, cfg.window_height};
    in_window = (col_ext >= org_x) && (col_ext < x_end) &&
                (row_ext >= org_y) && (row_ext < y_end);
    emit      = in_window && (cfg.scale_factor >= 3'd1) && (cfg.scale_factor <= 3'd4) &&
                (fmt_bytes(cfg.pixel_format) != 3'd0);
    ox        = 10'(col_ext - org_x);
    oy        = 10'(row_ext - org_y);
    ox_f      = {2'b00, ox} * {9'd0, cfg.scale_factor};
    oy_f      = {2'b00, oy} * {9'd0, cfg.scale_factor};
    col_last  = (col_ext == 11'(SRC_WIDTH - 1));
    row_last  = (row_ext == 11'(SRC_HEIGHT - 1));
    idx_wide  = {4'd0, item.color_index};
    in_range  = idx_wide < 13'(PALETTE_DEPTH);
    addr      = idx_wide[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (item.mode == MODE_PIXEL) && emit;
      if (accept && (item.mode == MODE_PIXEL)) begin
        if (col_last) begin
          column <= '0;
          row    <= row_last ? '0 : RW'(row_ext + 11'd1);
        end else begin
          column <= CW'(col_ext + 11'd1);
          row    <= row_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (item.mode == MODE_PALETTE) && in_range) begin
      palette_store[addr] <= item.palette_word;
    end
    if (accept && (item.mode == MODE_PIXEL)) begin
      rd_data     <= palette_store[addr];
      s1_ox_f     <= ox_f;
      s1_oy_f     <= oy_f;
      s1_in_range <= in_range;
    end
  end

  // Read stage: colour arrives from the store, offset bases are formed.
  assign bytes  = fmt_bytes(cfg.pixel_format);
  assign q_push = s1_valid;

  always_comb begin
    q_data.row_start = 24'({12'd0, s1_oy_f} * {10'd0, cfg.row_pitch});
    q_data.col_start = 14'({2'b00, s1_ox_f} * {11'd0, bytes});
    q_data.colour    = s1_in_range ? (rd_data & fmt_mask(cfg.pixel_format)) : 32'd0;
  end

endmodule

[sv/pprs_queue.sv]
// Short job queue that decouples the front part from the back part.
`timescale 1ns / 1ps

module pprs_queue import pprs_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  job_t          push_data,
  input  logic          pop,
  output job_t          head,
  output queue_status_t status
);

  job_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_LVL_W-1:0] level;
  logic                   do_pop;

  assign do_pop       = pop && (level != '0);
  assign head         = slots[rd_ptr];
  assign status.empty = (level == '0);
  assign status.level = level;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[sv/pprs_back.sv]
// Back part: walks the factor-by-factor block of each job and drives the result register.
`timescale 1ns / 1ps

module pprs_back import pprs_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  queue_status_t q_status,
  input  job_t          q_head,
  output logic          q_pop,
  output result_t       result,
  output logic          empty,
  input  logic          pop
);

  logic        busy;
  logic        out_valid;
  logic [23:0] line_off;
  logic [13:0] col_start;
  logic [13:0] col_cur;
  logic [1:0]  r;
  logic [1:0]  c;
  logic [31:0] colour;

  logic [1:0] fm1;
  logic [2:0] bytes;
  logic       out_free;
  logic       adv;
  logic       last_now;
  logic       load;

  assign fm1      = 2'(cfg.scale_factor - 3'd1);
  assign bytes    = fmt_bytes(cfg.pixel_format);
  assign out_free = !out_valid || pop;
  assign adv      = busy && out_free;
  assign last_now = (r == fm1) && (c == fm1);
  assign load     = !q_status.empty && (!busy || (adv && last_now));
  assign q_pop    = load;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= busy;
      end
      priority if (load) begin
        busy <= 1'b1;
      end else if (adv && last_now) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.byte_offset <= line_off + {10'd0, col_cur};
      result.pixel_value <= colour;
      result.last_write  <= last_now;
    end
    priority if (load) begin
      line_off  <= q_head.row_start;
      col_start <= q_head.col_start;
      col_cur   <= q_head.col_start;
      colour    <= q_head.colour;
      r         <= 2'd0;
      c         <= 2'd0;
    end else if (adv) begin
      if (c == fm1) begin
        c        <= 2'd0;
        col_cur  <= col_start;
        r        <= r + 2'd1;
        line_off <= line_off + {10'd0, cfg.row_pitch};
      end else begin
        c       <= c + 2'd1;
        col_cur <= col_cur + {11'd0, bytes};
      end
    end
  end

endmodule

[sv/palette_pixel_replication_scaler.sv]
// Top level of the palette pixel replication scaler: configuration registers and part wiring.
`timescale 1ns / 1ps

// Nearest-neighbor integer upscaler for a palette-indexed raster stream. Each request on the
// input side is either a palette store write (mode 1) or a source pixel (mode 0); pixels advance
// the column and row counters, and a pixel that falls inside the configured window produces
// scale_factor squared write requests on the result side, row by row, each carrying its
// destination byte offset, the palette colour masked to the pixel format, and last_write on the
// final one. An input request is accepted in any cycle that full is low. Results leave at one per
// cycle from the back part's output register while the receiver keeps popping, and a visible
// pixel yields 1, 4, 9 or 16 results at factors 1 to 4; a four-entry job queue lets the front
// keep accepting while the back is busy. The first result of a pixel passes through the store
// read stage, in which the offset bases are also formed, the queue, the back part's job registers
// and the output register. A palette entry must be written before any pixel reads it. The user
// must write configuration only while the block is idle; the block itself does not enforce this.

module palette_pixel_replication_scaler import pprs_pkg::*; #(
  parameter int SRC_WIDTH     = DEF_SRC_WIDTH,
  parameter int SRC_HEIGHT    = DEF_SRC_HEIGHT,
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   push,
  input  item_t                  item,
  output logic                   full,
  input  logic                   pop,
  output result_t                result,
  output logic                   empty
);

  cfg_t          cfg;
  queue_status_t q_status;
  logic          q_push;
  logic          q_pop;
  job_t          q_in;
  job_t          q_head;

  // Register file. Each write keeps only the bits its register holds.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_factor  <= 3'd1;
      cfg.pixel_format  <= FMT_16;
      cfg.row_pitch     <= 14'd0;
      cfg.window_width  <= 9'd256;
      cfg.window_height <= 8'd240;
      cfg.crop_enable   <= 1'b0;
      cfg.crop_top      <= 8'd0;
      cfg.crop_left     <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE_FACTOR:  cfg.scale_factor  <= cfg_data[2:0];
        REG_PIXEL_FORMAT:  cfg.pixel_format  <= cfg_data[1:0];
        REG_ROW_PITCH:     cfg.row_pitch     <= cfg_data[13:0];
        REG_WINDOW_WIDTH:  cfg.window_width  <= cfg_data[8:0];
        REG_WINDOW_HEIGHT: cfg.window_height <= cfg_data[7:0];
        REG_CROP_ENABLE:   cfg.crop_enable   <= cfg_data[0];
        REG_CROP_TOP:      cfg.crop_top      <= cfg_data[7:0];
        REG_CROP_LEFT:     cfg.crop_left     <= cfg_data[7:0];
      endcase
    end
  end

  // The front owns the palette store and counters, so store writes and pixel reads keep their
  // request order without any bypass logic.
  pprs_front #(
    .SRC_WIDTH     (SRC_WIDTH),
    .SRC_HEIGHT    (SRC_HEIGHT),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .item     (item),
    .full     (full),
    .q_status (q_status),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  pprs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  // The back loads the next job in the same cycle it issues the last write of the current one,
  // so consecutive 1x pixels stream at one result per cycle while the receiver keeps popping.
  pprs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_status (q_status),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

[sv/pprs_checker.sv]
// Port-level assertions for the scaler and the bind that attaches them.
`timescale 1ns / 1ps

module pprs_checker import pprs_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    full,
  input logic    pop,
  input logic    empty,
  input result_t result
);

  // Reset empties the output register, and no result can reach it straight after reset.
  a_reset_latency: assert property (@(posedge clk) rst |=> empty ##1 empty ##1 empty)
    else $error("result shown too soon after reset");

  // The queue is drained by reset, so requests are taken right away.
  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("full asserted right after reset");

  // A waiting result holds until it is popped.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

endmodule

bind palette_pixel_replication_scaler pprs_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .pop    (pop),
  .empty  (empty),
  .result (result)
);

[tb/sv/pprs_write_checker.sv]
// Watches the scaler's channels, predicts every destination write and compares it with the result.
`timescale 1ns / 1ps

module pprs_write_checker import pprs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   push,
  input  item_t                  item,
  input  logic                   full,
  input  logic                   pop,
  input  result_t                result,
  input  logic                   empty,
  output int                     mismatches,
  output int                     outstanding
);

  cfg_t        regs;
  logic [31:0] colors [0:DEF_PALETTE_DEPTH-1];
  int          col;
  int          row;
  int          fail_total;
  result_t     expected_writes [$];
  result_t     want;

  // Places one source pixel on the raster and queues the writes it should produce.
  task automatic replicate_pixel(item_t px);
    int          org_x;
    int          org_y;
    int          f;
    int          bpp;
    int          r;
    int          c;
    logic [31:0] mask;
    logic [31:0] colour;
    logic [31:0] off;
    result_t     w;
    if (px.frame_start) begin
      col = 0;
      row = 0;
    end
    org_x = regs.crop_enable ? int'(regs.crop_left) : 0;
    org_y = regs.crop_enable ? int'(regs.crop_top) : 0;
    f = int'(regs.scale_factor);
    case (regs.pixel_format)
      FMT_16: begin
        bpp = 2;
        mask = 32'h0000_FFFF;
      end
      FMT_24: begin
        bpp = 3;
        mask = 32'h00FF_FFFF;
      end
      FMT_32: begin
        bpp = 4;
        mask = 32'hFFFF_FFFF;
      end
      default: begin
        bpp = 0;
        mask = 32'h0;
      end
    endcase
    if (col >= org_x && col < org_x + int'(regs.window_width) &&
        row >= org_y && row < org_y + int'(regs.window_height) &&
        f >= 1 && f <= 4 && bpp != 0) begin
      colour = colors[px.color_index] & mask;
      for (r = 0; r < f; r++) begin
        for (c = 0; c < f; c++) begin
          off = ((row - org_y) * f + r) * int'(regs.row_pitch) + ((col - org_x) * f + c) * bpp;
          w.byte_offset = off[23:0];
          w.pixel_value = colour;
          w.last_write  = (r == f - 1) && (c == f - 1);
          expected_writes.push_back(w);
        end
      end
    end
    col++;
    if (col >= DEF_SRC_WIDTH) begin
      col = 0;
      row++;
      if (row >= DEF_SRC_HEIGHT) row = 0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.scale_factor  = 3'd1;
      regs.pixel_format  = FMT_16;
      regs.row_pitch     = '0;
      regs.window_width  = 9'd256;
      regs.window_height = 8'd240;
      regs.crop_enable   = 1'b0;
      regs.crop_top      = '0;
      regs.crop_left     = '0;
      col = 0;
      row = 0;
      expected_writes.delete();
    end else begin
      // Results are checked before the same edge's input is predicted; the pipeline
      // latency keeps a new pixel's writes from showing up in its own cycle.
      if (pop && !empty) begin
        if (expected_writes.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("unexpected write: offset %h value %h last %b",
                     result.byte_offset, result.pixel_value, result.last_write);
        end else begin
          want = expected_writes.pop_front();
          if (result.byte_offset !== want.byte_offset ||
              result.pixel_value !== want.pixel_value ||
              result.last_write !== want.last_write) begin
            fail_total++;
            if (fail_total <= 10)
              $display("write mismatch: expected offset %h value %h last %b, got %h %h %b",
                       want.byte_offset, want.pixel_value, want.last_write,
                       result.byte_offset, result.pixel_value, result.last_write);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SCALE_FACTOR:  regs.scale_factor  = cfg_data[2:0];
          REG_PIXEL_FORMAT:  regs.pixel_format  = cfg_data[1:0];
          REG_ROW_PITCH:     regs.row_pitch     = cfg_data[13:0];
          REG_WINDOW_WIDTH:  regs.window_width  = cfg_data[8:0];
          REG_WINDOW_HEIGHT: regs.window_height = cfg_data[7:0];
          REG_CROP_ENABLE:   regs.crop_enable   = cfg_data[0];
          REG_CROP_TOP:      regs.crop_top      = cfg_data[7:0];
          REG_CROP_LEFT:     regs.crop_left     = cfg_data[7:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        if (item.mode == MODE_PALETTE)
          colors[item.color_index] = item.palette_word;
        else
          replicate_pixel(item);
      end
    end
    outstanding <= expected_writes.size();
    mismatches  <= fail_total;
  end

endmodule

[tb/sv/palette_pixel_replication_scaler_tb.sv]
// Stimulus and verdict for the palette pixel replication scaler, with the write checker alongside.
`timescale 1ns / 1ps

module palette_pixel_replication_scaler_tb;
  import pprs_pkg::*;

  // A pixel format code that selects no format at all.
  localparam logic [1:0] FMT_NONE = 2'd3;

  // The receiver's long hold-off, the quiet time after the last write before a register
  // write (the pipeline is four stages deep), the wait before the verdict, and the watchdog
  // limit. The limit covers the long hold-off several times over, which dwarfs a full
  // sixteen-write pixel under the receiver's worst ordinary stall plus the sender's longest gap.
  localparam int LONG_HOLD  = 400;
  localparam int SETTLE     = 8;
  localparam int TAIL       = 16;
  localparam int IDLE_LIMIT = 2000;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   push      = 1'b0;
  item_t                  item      = '0;
  logic                   pop       = 1'b0;
  logic                   full;
  logic                   empty;
  result_t                result;
  int                     mismatches;
  int                     outstanding;

  bit                     long_hold_req = 1'b0;
  int                     burst_left    = 0;
  int                     idle_cycles   = 0;
  bit                     written [DEF_PALETTE_DEPTH];
  int                     known_idx [$];

  initial begin
    forever #2 clk = ~clk;
  end

  palette_pixel_replication_scaler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (item),
    .full      (full),
    .pop       (pop),
    .result    (result),
    .empty     (empty)
  );

  pprs_write_checker write_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .item        (item),
    .full        (full),
    .pop         (pop),
    .result      (result),
    .empty       (empty),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Watchdog: any accepted request, popped result or register write counts as progress. A run
  // whose quiet-cycle count reaches IDLE_LIMIT has hung.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", idle_cycles);
      $display("[palette_pixel_replication_scaler] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: pops according to a 32-bit stall pattern that is redrawn each time it
  // runs out. Some patterns are solid ones, so there are stretches with no stalls. When
  // the stimulus asks for it, the receiver holds off for the LONG_HOLD span so the job
  // queue fills and the block has to push back on its input.
  initial begin
    logic [31:0] stall_bits;
    int          stall_pos;
    stall_bits = '1;
    stall_pos  = 0;
    forever begin
      if (long_hold_req) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        if (stall_pos == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_bits = '1;
            1:       stall_bits = $urandom | $urandom;
            2:       stall_bits = $urandom;
            default: stall_bits = ($urandom & $urandom) | 32'h0101_0101;
          endcase
        end
        pop <= stall_bits[stall_pos];
        stall_pos = (stall_pos + 1) % 32;
        @(posedge clk);
      end
    end
  end

  // Offers one request and returns at the edge that accepts it. The sender works in
  // bursts; between bursts it usually drops push for a random gap, sometimes not at all.
  // Push stays high on return so back-to-back requests need no extra cycle.
  task automatic send_item(item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    burst_left--;
  endtask

  // Stops sending and waits until every predicted write has come out. Palette writes and
  // pixels outside the window leave nothing to wait for, so the SETTLE wait lets any
  // such request clear the pipeline before the block is treated as idle.
  task automatic drain;
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // Brings the block to idle and writes the whole register set.
  task automatic apply_setup(int sf, int fmt, int pitch, int ww, int wh, int ce, int ct,
                             int cl);
    drain();
    write_reg(REG_SCALE_FACTOR, sf);
    write_reg(REG_PIXEL_FORMAT, fmt);
    write_reg(REG_ROW_PITCH, pitch);
    write_reg(REG_WINDOW_WIDTH, ww);
    write_reg(REG_WINDOW_HEIGHT, wh);
    write_reg(REG_CROP_ENABLE, ce);
    write_reg(REG_CROP_TOP, ct);
    write_reg(REG_CROP_LEFT, cl);
    cfg_we <= 1'b0;
  endtask

  // Palette store write. Its frame_start bit is random noise the block must ignore.
  task automatic put_palette(int idx, logic [31:0] word, bit fs);
    item_t it;
    it.mode         = MODE_PALETTE;
    it.color_index  = 9'(idx);
    it.palette_word = word;
    it.frame_start  = fs;
    if (!written[idx]) begin
      written[idx] = 1'b1;
      known_idx.push_back(idx);
    end
    send_item(it);
  endtask

  // Source pixel. The palette word is unused in this mode and carries noise.
  task automatic send_pixel(int idx, bit fs);
    item_t it;
    it.mode         = MODE_PIXEL;
    it.color_index  = 9'(idx);
    it.palette_word = $urandom;
    it.frame_start  = fs;
    send_item(it);
  endtask

  // Pixels only ever name palette entries that have already been loaded.
  function automatic int any_known();
    return known_idx[$urandom_range(0, known_idx.size() - 1)];
  endfunction

  task automatic random_items(int n, int pct_palette);
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < pct_palette)
        put_palette($urandom_range(0, DEF_PALETTE_DEPTH - 1), $urandom,
                    $urandom_range(0, 1) == 1);
      else
        send_pixel(any_known(), $urandom_range(0, 99) < 4);
    end
  endtask

  // Draws a register set. Most draws give a valid factor and format and a window that
  // covers the first line, since random pixels rarely get past it; now and then the
  // factor or the format is out of range and nothing should come out.
  task automatic random_setup;
    int sf;
    int fmt;
    int pitch;
    int ww;
    int wh;
    int ce;
    int ct;
    int cl;
    sf = $urandom_range(4, 7);
    if (sf == 4) sf = 0;
    if ($urandom_range(0, 9) != 0) sf = $urandom_range(1, 4);
    case ($urandom_range(0, 2))
      0:       fmt = int'(FMT_16);
      1:       fmt = int'(FMT_24);
      default: fmt = int'(FMT_32);
    endcase
    if ($urandom_range(0, 19) == 0) fmt = int'(FMT_NONE);
    case ($urandom_range(0, 3))
      0:       pitch = 0;
      1:       pitch = 16383;
      default: pitch = $urandom_range(0, 16383);
    endcase
    ww = ($urandom_range(0, 9) == 0) ? 256 : $urandom_range(1, 256);
    wh = ($urandom_range(0, 9) == 0) ? 240 : $urandom_range(1, 240);
    ce = $urandom_range(0, 1);
    ct = $urandom_range(0, 1) ? 0 : $urandom_range(0, 3);
    cl = $urandom_range(0, 40);
    apply_setup(sf, fmt, pitch, ww, wh, ce, ct, cl);
  endtask

  initial begin
    int ph;
    int k;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Largest factor, widest format and pitch, full window. The palette is loaded at the
    // extreme entries with all-ones and all-zeros colours; three of the store writes carry
    // frame_start, which must leave the raster counters alone.
    apply_setup(4, int'(FMT_32), 16383, 256, 240, 0, 0, 0);
    put_palette(0, 32'hFFFF_FFFF, 1'b1);
    put_palette(DEF_PALETTE_DEPTH - 1, 32'h0000_0000, 1'b0);
    put_palette(1, 32'hAAAA_AAAA, 1'b0);
    put_palette(DEF_PALETTE_DEPTH - 2, 32'h5555_5555, 1'b1);
    send_pixel(0, 1'b1);
    send_pixel(DEF_PALETTE_DEPTH - 1, 1'b0);
    send_pixel(1, 1'b0);
    send_pixel(DEF_PALETTE_DEPTH - 2, 1'b0);
    put_palette(2, 32'h1234_5678, 1'b1);
    send_pixel(2, 1'b0);
    // A new frame puts the next pixel back in the first column.
    send_pixel(0, 1'b1);

    // Cropped two-pixel window at 1x 24 bpp: the first and last pixels of the line
    // segment fall outside, the middle two land three bytes apart.
    apply_setup(1, int'(FMT_24), 0, 2, 1, 1, 0, 1);
    send_pixel(0, 1'b1);
    send_pixel(1, 1'b0);
    send_pixel(2, 1'b0);
    send_pixel(DEF_PALETTE_DEPTH - 1, 1'b0);

    // Factor zero and factor seven, an invalid pixel format, an empty window, and a crop
    // that starts on the last line: none of these may produce a write.
    apply_setup(0, int'(FMT_16), 100, 256, 240, 0, 0, 0);
    send_pixel(0, 1'b1);
    send_pixel(1, 1'b0);
    apply_setup(7, int'(FMT_16), 100, 256, 240, 0, 0, 0);
    send_pixel(2, 1'b0);
    apply_setup(2, int'(FMT_NONE), 100, 256, 240, 0, 0, 0);
    send_pixel(0, 1'b1);
    send_pixel(1, 1'b0);
    apply_setup(3, int'(FMT_16), 5, 0, 0, 0, 0, 0);
    send_pixel(0, 1'b1);
    apply_setup(1, int'(FMT_32), 7, 256, 240, 1, 239, 0);
    send_pixel(0, 1'b1);
    send_pixel(1, 1'b0);

    // Random part. The first phase runs 4x pixels into a receiver that holds off, so the
    // job queue fills and the input stalls.
    apply_setup(4, int'(FMT_24), $urandom_range(0, 16383), 256, 240, 0, 0, 0);
    long_hold_req = 1'b1;
    random_items(40, 5);
    for (ph = 0; ph < 4; ph++) begin
      random_setup();
      random_items(20, 15);
      // Once in the middle of a phase the sender waits for every write to come out.
      if (ph == 2) drain();
      random_items(20, 15);
    end

    // A three-column window one column in from the left at 2x: the first pixel of each
    // frame falls outside, the next three land in it, and the writes of each of those pixels
    // span two destination rows.
    apply_setup(2, int'(FMT_24), $urandom_range(1, 16383), 3, 3, 1, 0, 1);
    for (k = 0; k < 56; k++)
      send_pixel(any_known(), (k % 28) == 0);

    drain();
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("[palette_pixel_replication_scaler] OK");
    else
      $display("[palette_pixel_replication_scaler] ERROR");
    $finish;
  end

endmodule

[sim.f]
sv/pprs_pkg.sv
sv/pprs_front.sv
sv/pprs_queue.sv
sv/pprs_back.sv
sv/palette_pixel_replication_scaler.sv
sv/pprs_checker.sv
tb/sv/pprs_write_checker.sv
tb/sv/palette_pixel_replication_scaler_tb.sv
